// ----- sv/function_key_scan_fsm_defines.svh -----
// assertion macros for the function-key scan block
`ifndef FUNCTION_KEY_SCAN_FSM_DEFINES_SVH
`define FUNCTION_KEY_SCAN_FSM_DEFINES_SVH

// same-cycle implication, checked on clk_i outside reset
`define FKSCAN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fkscan: same-cycle check failed");

// next-cycle implication, checked on clk_i outside reset
`define FKSCAN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fkscan: next-cycle check failed");

`endif

// ----- sv/fkscan_pkg.sv -----
// types and constants shared by the function-key scan block
package fkscan_pkg;

  // configuration port geometry
  localparam int unsigned PeriodW = 24;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgLongPress  = 2'd0,
    CfgRefreshEn  = 2'd1,
    CfgSpeedEn    = 2'd2,
    CfgUnused     = 2'd3
  } cfg_idx_e;

  localparam logic [PeriodW-1:0] LongPressReset = 24'd1000000;

  // scan machine states, one-hot
  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StA11    = 7'b0000010,
    StA12    = 7'b0000100,
    StCheck  = 7'b0001000,
    StDone   = 7'b0010000,
    StRcheck = 7'b0100000,
    StRdone  = 7'b1000000
  } scan_state_e;

  // forced row patterns and idle columns
  localparam logic [7:0] RowsA11    = 8'hF7;
  localparam logic [7:0] RowsA12    = 8'hEF;
  localparam logic [4:0] ColsIdle   = 5'h1F;

  // strobe patterns
  localparam logic [9:0] StrobeF1 = 10'h001;
  localparam logic [9:0] StrobeF4 = 10'h008;
  localparam logic [9:0] StrobeF9 = 10'h100;

  // strobe bit positions of the hotkeys
  localparam int unsigned BitF2 = 1;
  localparam int unsigned BitF3 = 2;
  localparam int unsigned BitF7 = 6;
  localparam int unsigned BitF8 = 7;

  typedef struct packed {
    logic       m1_button_n;
    logic       reset_button_n;
    logic [7:0] row_bits;
    logic [4:0] column_bits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] rows_out;
    logic [4:0] columns_out;
    logic [9:0] key_strobes;
    logic       pulse_f2;
    logic       pulse_f3;
    logic       pulse_f7;
    logic       pulse_f8;
  } out_word_t;

  // timer control from the scan machine
  typedef struct packed {
    logic step;
    logic load;
  } timer_ctrl_t;

  // A12 column order is reversed: column 4 lands on F6, column 0 on F10
  function automatic logic [4:0] mirror5(input logic [4:0] v);
    mirror5 = {v[0], v[1], v[2], v[3], v[4]};
  endfunction

endpackage

// ----- sv/function_key_scan_fsm.sv -----
// top level of the function-key scan state machine
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i          | to block
//  out     | out_valid_o, out_ready_i, out_data_o       | from block
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, ... | to block
//
// One word per cycle unless out stalls: state and result are computed from the
// accepted word and the state registers, and land in a one-word result register.
// A new word is taken whenever the result register is empty or is being drained.
// Reset puts the machine in idle, clears timer, cancel flag and strobes, and loads
// the register defaults; no clearing pass follows.
// A stall on the out channel holds the result and back-pressures in_ready_o.
// The cfg channel is always ready; writes to an unused index are dropped.
`include "function_key_scan_fsm_defines.svh"

module function_key_scan_fsm #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fkscan_pkg::in_word_t            in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fkscan_pkg::out_word_t           out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fkscan_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fkscan_pkg::PeriodW-1:0]  cfg_data_i
);
  import fkscan_pkg::*;

  logic [PeriodW-1:0] long_press_q;
  logic               refresh_en_q;
  logic               speed_en_q;

  scan_state_e state_q, state_d;
  logic        cancel_q, cancel_d;
  logic [9:0]  strobe_q, strobe_d;
  logic        out_valid_q;
  out_word_t   out_q, out_d;

  logic        accept;
  logic        m1_down, rst_down;
  logic [4:0]  ncols;
  logic        expired;
  logic [9:0]  rising;
  timer_ctrl_t timer_ctrl;
  logic        chk_f2_out;
  logic        chk_cols_out;

  // handshakes
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign m1_down  = !in_data_i.m1_button_n;
  assign rst_down = !in_data_i.reset_button_n;
  assign ncols    = ~in_data_i.column_bits;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LongPressReset;
      refresh_en_q <= 1'b1;
      speed_en_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLongPress: long_press_q <= cfg_data_i;
        CfgRefreshEn: refresh_en_q <= cfg_data_i[0];
        CfgSpeedEn:   speed_en_q   <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // press timer
  assign timer_ctrl.step = accept;
  assign timer_ctrl.load = (state_q == StIdle) && (m1_down || rst_down);

  fkscan_timer #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (timer_ctrl),
    .period_i (long_press_q),
    .expired_o(expired)
  );

  // next scan state
  always_comb begin
    case (state_q)
      StIdle: begin
        if (rst_down) begin
          state_d = StRcheck;
        end else if (m1_down) begin
          state_d = StA11;
        end else begin
          state_d = StIdle;
        end
      end
      StA11:    state_d = StA12;
      StA12:    state_d = StCheck;
      StCheck:  state_d = m1_down ? StA11 : StDone;
      StDone:   state_d = StIdle;
      StRcheck: state_d = rst_down ? StRcheck : StRdone;
      StRdone:  state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // cancel flag: any key seen outside idle
  always_comb begin
    if (state_d == StIdle) begin
      cancel_d = 1'b0;
    end else if (in_data_i.column_bits != ColsIdle) begin
      cancel_d = 1'b1;
    end else begin
      cancel_d = cancel_q;
    end
  end

  // strobes by the new state
  always_comb begin
    case (state_d)
      StA11:   strobe_d = {strobe_q[9:5], ncols};
      StA12:   strobe_d = {mirror5(ncols), strobe_q[4:0]};
      StDone:  strobe_d = (!expired && !cancel_d) ? StrobeF9 : '0;
      StRdone: strobe_d = expired ? StrobeF1 : StrobeF4;
      StIdle:  strobe_d = '0;
      default: strobe_d = strobe_q;
    endcase
  end

  assign rising = strobe_d & ~strobe_q;

  // result word
  always_comb begin
    case (state_d)
      StIdle:  out_d.rows_out = in_data_i.row_bits;
      StA11:   out_d.rows_out = RowsA11;
      default: out_d.rows_out = RowsA12;
    endcase
    out_d.columns_out = (state_d == StIdle) ? in_data_i.column_bits : ColsIdle;
    out_d.key_strobes = strobe_d;
    out_d.pulse_f2    = rising[BitF2];
    out_d.pulse_f3    = rising[BitF3] & refresh_en_q;
    out_d.pulse_f7    = rising[BitF7];
    out_d.pulse_f8    = rising[BitF8] & speed_en_q;
  end

  // machine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cancel_q <= 1'b0;
      strobe_q <= '0;
    end else if (accept) begin
      state_q  <= state_d;
      cancel_q <= cancel_d;
      strobe_q <= strobe_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  assign chk_f2_out   = out_valid_o && out_data_o.pulse_f2;
  assign chk_cols_out = out_valid_o && (out_data_o.columns_out != ColsIdle);

  `FKSCAN_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_o)
  `FKSCAN_ASSERT_NOW(a_f2_pulse_has_strobe, chk_f2_out, out_data_o.key_strobes[BitF2])
  `FKSCAN_ASSERT_NOW(a_idle_cols_no_strobe, chk_cols_out, out_data_o.key_strobes == '0)

endmodule

// ----- sv/fkscan_timer.sv -----
// press timer: reload on a button press in idle, else count down to zero
module fkscan_timer #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fkscan_pkg::timer_ctrl_t      ctrl_i,
  input  logic [fkscan_pkg::PeriodW-1:0] period_i,
  output logic                         expired_o
);
  import fkscan_pkg::*;

  logic [TIMER_WIDTH-1:0] timer_q, timer_d;

  // reload or saturating decrement
  always_comb begin
    if (ctrl_i.load) begin
      timer_d = TIMER_WIDTH'(period_i);
    end else if (timer_q != '0) begin
      timer_d = timer_q - 1'b1;
    end else begin
      timer_d = timer_q;
    end
  end

  // expiry as seen after this word's update
  assign expired_o = (timer_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
    end else if (ctrl_i.step) begin
      timer_q <= timer_d;
    end
  end

endmodule

// ----- test/fkscan_checker.sv -----
// scoreboard for the function-key scan block: per-tick prediction and result compare
module fkscan_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  fkscan_pkg::in_word_t            in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  fkscan_pkg::out_word_t           out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [fkscan_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fkscan_pkg::PeriodW-1:0]  cfg_data_i,
  output int unsigned                     pending_o,
  output int unsigned                     mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fkscan_pkg::*;

  // shadow registers
  logic [PeriodW-1:0] period_q;
  logic               refresh_en_q;
  logic               speed_en_q;

  // shadow scan machine
  scan_state_e        scan_q;
  logic [PeriodW-1:0] press_timer_q;
  logic               cancel_q;
  logic [9:0]         strobes_q;
  logic [9:0]         last_strobes_q;

  out_word_t predicted_words[$];
  out_word_t want_word;
  out_word_t next_word;

  // advance the shadow machine by one tick and form the result word
  task automatic predict_scan_tick(input in_word_t w, output out_word_t r);
    logic       m1_down;
    logic       rst_down;
    logic       expired;
    logic [4:0] pressed;
    logic [9:0] rising;
    m1_down  = !w.m1_button_n;
    rst_down = !w.reset_button_n;
    pressed  = ~w.column_bits;

    // press timer: reload on a press seen in idle, else count down to zero
    if (scan_q == StIdle && (m1_down || rst_down)) begin
      press_timer_q = period_q;
    end else if (press_timer_q != '0) begin
      press_timer_q = press_timer_q - 1'b1;
    end
    expired = (press_timer_q == '0);

    // next state
    case (scan_q)
      StIdle: begin
        if (rst_down) scan_q = StRcheck;
        else if (m1_down) scan_q = StA11;
      end
      StA11: scan_q = StA12;
      StA12: scan_q = StCheck;
      StCheck: begin
        if (m1_down) scan_q = StA11;
        else scan_q = StDone;
      end
      StRcheck: begin
        if (!rst_down) scan_q = StRdone;
      end
      default: scan_q = StIdle;
    endcase

    last_strobes_q = strobes_q;

    // any key seen outside idle cancels the F9 strobe
    if (scan_q == StIdle) cancel_q = 1'b0;
    else if (w.column_bits != ColsIdle) cancel_q = 1'b1;

    // strobes by the new state
    case (scan_q)
      StA11: strobes_q[4:0] = pressed;
      StA12: begin
        for (int i = 0; i < 5; i++) strobes_q[5 + i] = pressed[4 - i];
      end
      StDone: strobes_q = (!expired && !cancel_q) ? StrobeF9 : '0;
      StRdone: strobes_q = expired ? StrobeF1 : StrobeF4;
      StIdle: strobes_q = '0;
      default: ;
    endcase

    rising = strobes_q & ~last_strobes_q;

    if (scan_q == StIdle) r.rows_out = w.row_bits;
    else if (scan_q == StA11) r.rows_out = RowsA11;
    else r.rows_out = RowsA12;
    r.columns_out = (scan_q == StIdle) ? w.column_bits : ColsIdle;
    r.key_strobes = strobes_q;
    r.pulse_f2    = rising[BitF2];
    r.pulse_f3    = rising[BitF3] & refresh_en_q;
    r.pulse_f7    = rising[BitF7];
    r.pulse_f8    = rising[BitF8] & speed_en_q;
  endtask

  task automatic compare_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
      mismatches_o = mismatches_o + 1;
    end
  endtask

  // results are checked before new words are predicted in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q       = LongPressReset;
      refresh_en_q   = 1'b1;
      speed_en_q     = 1'b1;
      scan_q         = StIdle;
      press_timer_q  = '0;
      cancel_q       = 1'b0;
      strobes_q      = '0;
      last_strobes_q = '0;
      predicted_words.delete();
      pending_o      = 0;
      mismatches_o   = 0;
    end else begin
      // result word
      if (out_valid_i && out_ready_i) begin
        if (predicted_words.size() == 0) begin
          $display("%0t ns: result word expected none, got 0x%0h", $time, out_data_i);
          mismatches_o = mismatches_o + 1;
        end else begin
          want_word = predicted_words.pop_front();
          compare_field("rows_out", want_word.rows_out, out_data_i.rows_out);
          compare_field("columns_out", want_word.columns_out, out_data_i.columns_out);
          compare_field("key_strobes", want_word.key_strobes, out_data_i.key_strobes);
          compare_field("pulse_f2", want_word.pulse_f2, out_data_i.pulse_f2);
          compare_field("pulse_f3", want_word.pulse_f3, out_data_i.pulse_f3);
          compare_field("pulse_f7", want_word.pulse_f7, out_data_i.pulse_f7);
          compare_field("pulse_f8", want_word.pulse_f8, out_data_i.pulse_f8);
        end
      end

      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgLongPress: period_q = cfg_data_i;
          CfgRefreshEn: refresh_en_q = cfg_data_i[0];
          CfgSpeedEn: speed_en_q = cfg_data_i[0];
          default: ;
        endcase
      end

      // input word
      if (in_valid_i && in_ready_i) begin
        predict_scan_tick(in_data_i, next_word);
        predicted_words.push_back(next_word);
      end

      pending_o = predicted_words.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// testbench top for the function-key scan state machine: stimulus, flow control and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fkscan_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned RandomTicks = 1750;
  localparam int unsigned PhaseCount  = 8;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_word = '1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [PeriodW-1:0] cfg_data = '0;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned stall_pct = 0;
  int unsigned burst_left = 0;
  int unsigned ticks_sent = 0;
  bit          steady_sender = 1'b0;
  logic [PeriodW-1:0] period_now = LongPressReset;

  function_key_scan_fsm uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  fkscan_checker scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb NOT OK");
    $finish;
  end

  // receiver back-pressure at a stall rate drawn at random: none, 30, 60 or 90 percent
  always @(negedge clk) begin
    if (cycle_count % 128 == 0) begin
      case ($urandom_range(4))
        0, 1: stall_pct = 0;
        2: stall_pct = 30;
        3: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  function automatic in_word_t make_word(logic m1_n, logic rst_btn_n, logic [7:0] rows,
                                         logic [4:0] cols);
    in_word_t w;
    w.m1_button_n    = m1_n;
    w.reset_button_n = rst_btn_n;
    w.row_bits       = rows;
    w.column_bits    = cols;
    return w;
  endfunction

  // mostly no key, else one key or a random mix
  function automatic logic [4:0] pick_columns(int unsigned key_pct);
    if ($urandom_range(99) >= key_pct) return ColsIdle;
    if ($urandom_range(1) != 0) return ~(5'b1 << $urandom_range(4));
    return 5'($urandom_range(31));
  endfunction

  // send one word, with random gaps between bursts unless steady_sender is set
  task automatic send_tick(input in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      if (!steady_sender && $urandom_range(2) != 0) begin
        gap = $urandom_range(6, 1);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // stop sending and wait until every result word has come back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [PeriodW-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // m1 held for some ticks, then released long enough for the scan to finish
  task automatic press_m1(input int unsigned hold, input int unsigned key_pct);
    int unsigned tail;
    tail = $urandom_range(5, 3);
    send_tick(make_word(1'b0, 1'b1, 8'($urandom), pick_columns(key_pct)));
    for (int unsigned k = 1; k < hold; k++) begin
      send_tick(make_word(1'b0, $urandom_range(9) != 0, 8'($urandom), pick_columns(key_pct)));
    end
    for (int unsigned k = 0; k < tail; k++) begin
      send_tick(make_word(1'b1, 1'b1, 8'($urandom), pick_columns(key_pct / 2)));
    end
  endtask

  // reset button held, then released
  task automatic press_reset(input int unsigned hold);
    int unsigned tail;
    tail = $urandom_range(3, 1);
    for (int unsigned k = 0; k < hold; k++) begin
      send_tick(make_word($urandom_range(1) != 0, 1'b0, 8'($urandom), pick_columns(30)));
    end
    for (int unsigned k = 0; k < tail; k++) begin
      send_tick(make_word(1'b1, 1'b1, 8'($urandom), pick_columns(20)));
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned hold_cap;
    int unsigned pick;
    logic        refresh_bit;
    logic        speed_bit;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle pass-through extremes
    send_tick(make_word(1'b1, 1'b1, 8'h00, 5'h00));
    send_tick(make_word(1'b1, 1'b1, 8'hFF, ColsIdle));
    // scan with F2 and F7, a second pass with F3 and F8, then a cancelled done
    send_tick(make_word(1'b0, 1'b1, 8'hA5, 5'h1D));
    send_tick(make_word(1'b0, 1'b1, 8'h5A, 5'h17));
    send_tick(make_word(1'b0, 1'b1, 8'h3C, ColsIdle));
    send_tick(make_word(1'b0, 1'b1, 8'hC3, 5'h1B));
    send_tick(make_word(1'b0, 1'b1, 8'h0F, 5'h1B));
    send_tick(make_word(1'b1, 1'b1, 8'hF0, ColsIdle));
    send_tick(make_word(1'b1, 1'b1, 8'h81, 5'h00));
    send_tick(make_word(1'b1, 1'b1, 8'h7E, ColsIdle));
    // clean short press gives F9
    send_tick(make_word(1'b0, 1'b1, 8'h11, ColsIdle));
    send_tick(make_word(1'b1, 1'b1, 8'h22, ColsIdle));
    send_tick(make_word(1'b1, 1'b1, 8'h44, ColsIdle));
    send_tick(make_word(1'b1, 1'b1, 8'h88, ColsIdle));
    send_tick(make_word(1'b1, 1'b1, 8'h55, ColsIdle));
    // every key down in both rows
    send_tick(make_word(1'b0, 1'b1, 8'h00, 5'h00));
    send_tick(make_word(1'b0, 1'b1, 8'hFF, 5'h00));
    send_tick(make_word(1'b1, 1'b1, 8'hAA, ColsIdle));
    send_tick(make_word(1'b1, 1'b1, 8'h99, ColsIdle));
    send_tick(make_word(1'b1, 1'b1, 8'h66, ColsIdle));
    // both buttons at once: reset path wins, short press gives F4
    send_tick(make_word(1'b0, 1'b0, 8'h12, ColsIdle));
    send_tick(make_word(1'b1, 1'b0, 8'h34, 5'h0E));
    send_tick(make_word(1'b1, 1'b1, 8'h56, ColsIdle));
    send_tick(make_word(1'b1, 1'b1, 8'h78, ColsIdle));

    // random phases, each under its own register setting
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      settle();
      case (phase)
        0: begin
          period_now  = '0;
          refresh_bit = 1'b0;
          speed_bit   = 1'b0;
        end
        1: begin
          period_now  = '1;
          refresh_bit = 1'b1;
          speed_bit   = 1'b1;
        end
        default: begin
          period_now  = PeriodW'($urandom_range(40, 1));
          refresh_bit = $urandom_range(1) != 0;
          speed_bit   = $urandom_range(1) != 0;
        end
      endcase
      write_register(CfgLongPress, period_now);
      write_register(CfgRefreshEn, {23'($urandom), refresh_bit});
      write_register(CfgSpeedEn, {23'($urandom), speed_bit});
      if (phase == 0) write_register(CfgUnused, 24'($urandom));

      steady_sender = (phase % 3 == 2);
      hold_cap = (period_now < 30) ? 2 * period_now + 6 : 20;
      target = ticks_sent + RandomTicks / PhaseCount;
      while (ticks_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          press_m1($urandom_range(hold_cap, 1), ($urandom_range(1) != 0) ? 0 : 40);
        end else if (pick < 80) begin
          press_reset($urandom_range(hold_cap, 1));
        end else begin
          repeat ($urandom_range(4, 1)) send_tick(in_word_t'(15'($urandom)));
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/fkscan_pkg.sv
sv/fkscan_timer.sv
sv/function_key_scan_fsm.sv
test/fkscan_checker.sv
test/tb.sv
